FILE: rtl/core/pcfp_pkg.sv
// shared types and constants of the pwm command frame parser
`default_nettype none

package pcfp_pkg;

	localparam logic [7:0] BYTE_START  = 8'h9B;
	localparam logic [7:0] BYTE_LENGTH = 8'h06;
	localparam logic [7:0] BYTE_END    = 8'hFE;
	localparam logic [7:0] CHANNEL_MAX = 8'd16;
	localparam logic [7:0] PWM_LOW     = 8'd10;
	localparam logic [7:0] PWM_HIGH    = 8'd25;

	typedef enum logic [2:0] {
		POS_IDLE    = 3'd0,
		POS_START   = 3'd1,
		POS_LENGTH  = 3'd2,
		POS_CHANNEL = 3'd3,
		POS_MIN     = 3'd4,
		POS_MAX     = 3'd5,
		POS_END     = 3'd6
	} pcfp_pos_t;

	typedef enum logic [1:0] {
		ST_IGNORED  = 2'd0,
		ST_PROGRESS = 2'd1,
		ST_REJECTED = 2'd2,
		ST_COMPLETE = 2'd3
	} pcfp_status_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} pcfp_stage_t;

	typedef struct packed {
		pcfp_status_t status;
		logic [4:0]   channel;
		logic [4:0]   min_pwm;
		logic [4:0]   max_pwm;
	} pcfp_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/pcfp_rx_if.sv
// request channel carrying received bytes
`default_nettype none

interface pcfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pcfp_res_if.sv
// request channel carrying one parse status per byte
`default_nettype none

interface pcfp_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] frame_status;
	logic [4:0] channel_out;
	logic [4:0] min_pwm_out;
	logic [4:0] max_pwm_out;

	modport source(
		output valid, output frame_status, output channel_out,
		output min_pwm_out, output max_pwm_out, input ready
	);
	modport sink(
		input valid, input frame_status, input channel_out,
		input min_pwm_out, input max_pwm_out, output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/pwm_command_frame_parser.sv
// top level of the pwm command frame parser
//
//   channel  dir  payload                                         accepted when
//   rx       in   rx_byte[7:0]                                    valid && ready
//   res      out  frame_status[1:0] channel_out, min_pwm_out,     valid && ready
//                 max_pwm_out[4:0]
//
// one byte per cycle sustained while res is ready; a byte passes from the input register
// through the position logic into the result register
// reset clears the position to idle, the held fields to zero and both valid flags
// a stalled result holds its register while the input register still takes one
// more byte; the parser state moves only when a byte passes into the result register
`default_nettype none

module pwm_command_frame_parser (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pcfp_rx_if.sink    rx,
	pcfp_res_if.source res
);
	import pcfp_pkg::*;

	pcfp_stage_t  stage;
	pcfp_result_t result;
	logic         advance;

	assign advance = stage.valid && (!res.valid || res.ready);

	pcfp_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.advance (advance),
		.stage   (stage)
	);

	pcfp_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.stage   (stage),
		.advance (advance),
		.result  (result)
	);

	pcfp_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.result  (result),
		.res     (res)
	);

endmodule

`default_nettype wire

FILE: rtl/core/pcfp_in_stage.sv
// input register for received bytes
`default_nettype none

module pcfp_in_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	pcfp_rx_if.sink                   rx,
	input  wire logic                 advance,
	output pcfp_pkg::pcfp_stage_t     stage
);
	import pcfp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       take;

	assign rx.ready = !valid_s1 || advance;
	assign take     = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign stage.valid   = valid_s1;
	assign stage.rx_byte = byte_s1;

endmodule

`default_nettype wire

FILE: rtl/core/pcfp_fsm.sv
// frame position state machine and held fields
`default_nettype none

module pcfp_fsm (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  pcfp_pkg::pcfp_stage_t     stage,
	input  wire logic                 advance,
	output pcfp_pkg::pcfp_result_t    result
);
	import pcfp_pkg::*;

	pcfp_pos_t  pos_q, pos_d;
	logic [4:0] channel_q, channel_d;
	logic [4:0] min_q, min_d;
	logic [4:0] max_q, max_d;
	logic [7:0] b;
	logic       pwm_ok;

	assign b      = stage.rx_byte;
	assign pwm_ok = (b >= PWM_LOW) && (b <= PWM_HIGH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_IDLE;
			channel_q <= 5'd0;
			min_q     <= 5'd0;
			max_q     <= 5'd0;
		end else if (advance) begin
			pos_q     <= pos_d;
			channel_q <= channel_d;
			min_q     <= min_d;
			max_q     <= max_d;
		end
	end

	always_comb begin
		pos_d          = POS_IDLE;
		channel_d      = channel_q;
		min_d          = min_q;
		max_d          = max_q;
		result.status  = ST_REJECTED;
		result.channel = 5'd0;
		result.min_pwm = 5'd0;
		result.max_pwm = 5'd0;
		if (b == BYTE_START) begin
			pos_d         = POS_LENGTH;
			result.status = ST_PROGRESS;
		end else begin
			unique case (pos_q)
				POS_START: begin
					pos_d = POS_IDLE;
				end
				POS_LENGTH: begin
					if (b == BYTE_LENGTH) begin
						pos_d         = POS_CHANNEL;
						result.status = ST_PROGRESS;
					end
				end
				POS_CHANNEL: begin
					if (b <= CHANNEL_MAX) begin
						channel_d     = b[4:0];
						pos_d         = POS_MIN;
						result.status = ST_PROGRESS;
					end
				end
				POS_MIN: begin
					if (pwm_ok) begin
						min_d         = b[4:0];
						pos_d         = POS_MAX;
						result.status = ST_PROGRESS;
					end
				end
				POS_MAX: begin
					if (pwm_ok) begin
						max_d         = b[4:0];
						pos_d         = POS_END;
						result.status = ST_PROGRESS;
					end
				end
				POS_END: begin
					if (b == BYTE_END) begin
						pos_d          = POS_START;
						result.status  = ST_COMPLETE;
						result.channel = channel_q;
						result.min_pwm = min_q;
						result.max_pwm = max_q;
					end
				end
				default: begin
					pos_d         = POS_IDLE;
					result.status = ST_IGNORED;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_start_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (b == BYTE_START) |=> pos_q == POS_LENGTH)
		else $error("start byte did not restart the frame");

	a_complete_waits: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (result.status == ST_COMPLETE) |=> pos_q == POS_START)
		else $error("complete frame not followed by wait for start");

	a_reject_idles: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (result.status == ST_REJECTED) |=> pos_q == POS_IDLE)
		else $error("rejected byte did not drop to idle");

	a_complete_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		(result.status == ST_COMPLETE) |->
			(result.channel <= 5'd16) && (result.min_pwm >= 5'd10) &&
			(result.min_pwm <= 5'd25) && (result.max_pwm >= 5'd10) &&
			(result.max_pwm <= 5'd25))
		else $error("complete frame with field out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/pcfp_out_stage.sv
// result register driving the status channel
`default_nettype none

module pcfp_out_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 advance,
	input  pcfp_pkg::pcfp_result_t    result,
	pcfp_res_if.source                res
);
	import pcfp_pkg::*;

	logic         valid_s2;
	pcfp_result_t result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign res.valid        = valid_s2;
	assign res.frame_status = result_s2.status;
	assign res.channel_out  = result_s2.channel;
	assign res.min_pwm_out  = result_s2.min_pwm;
	assign res.max_pwm_out  = result_s2.max_pwm;

endmodule

`default_nettype wire

FILE: tb/sv/pcfp_frame_check.sv
// status predictor and comparator for the pwm command frame parser testbench
`timescale 1ns / 100ps

module pcfp_frame_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [1:0] out_status,
	input  logic [4:0] out_channel,
	input  logic [4:0] out_min_pwm,
	input  logic [4:0] out_max_pwm,
	output int         mismatches,
	output int         pending,
	output int         checked,
	output int         completes,
	output int         rejects
);
	import pcfp_pkg::*;

	pcfp_pos_t    parse_pos;
	logic [4:0]   held_channel;
	logic [4:0]   held_min;
	logic [4:0]   held_max;
	pcfp_result_t expected_status_q[$];

	function automatic logic pwm_in_range(input logic [7:0] b);
		return b >= PWM_LOW && b <= PWM_HIGH;
	endfunction

	function automatic pcfp_result_t parse_byte(input logic [7:0] b);
		pcfp_result_t r;
		r = '{status: ST_REJECTED, channel: 5'd0, min_pwm: 5'd0, max_pwm: 5'd0};
		if (b == BYTE_START) begin
			parse_pos = POS_LENGTH;
			r.status = ST_PROGRESS;
		end else begin
			unique case (parse_pos)
				POS_START: begin
					parse_pos = POS_IDLE;
				end
				POS_LENGTH: begin
					if (b == BYTE_LENGTH) begin
						parse_pos = POS_CHANNEL;
						r.status = ST_PROGRESS;
					end else begin
						parse_pos = POS_IDLE;
					end
				end
				POS_CHANNEL: begin
					if (b <= CHANNEL_MAX) begin
						held_channel = b[4:0];
						parse_pos = POS_MIN;
						r.status = ST_PROGRESS;
					end else begin
						parse_pos = POS_IDLE;
					end
				end
				POS_MIN: begin
					if (pwm_in_range(b)) begin
						held_min = b[4:0];
						parse_pos = POS_MAX;
						r.status = ST_PROGRESS;
					end else begin
						parse_pos = POS_IDLE;
					end
				end
				POS_MAX: begin
					if (pwm_in_range(b)) begin
						held_max = b[4:0];
						parse_pos = POS_END;
						r.status = ST_PROGRESS;
					end else begin
						parse_pos = POS_IDLE;
					end
				end
				POS_END: begin
					if (b == BYTE_END) begin
						parse_pos = POS_START;
						r.status = ST_COMPLETE;
						r.channel = held_channel;
						r.min_pwm = held_min;
						r.max_pwm = held_max;
					end else begin
						parse_pos = POS_IDLE;
					end
				end
				default: begin
					parse_pos = POS_IDLE;
					r.status = ST_IGNORED;
				end
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pcfp_result_t exp_r;
		if (!arst_n) begin
			parse_pos = POS_IDLE;
			held_channel = 5'd0;
			held_min = 5'd0;
			held_max = 5'd0;
			expected_status_q.delete();
			mismatches = 0;
			checked = 0;
			completes = 0;
			rejects = 0;
		end else begin
			if (in_valid && in_ready)
				expected_status_q.push_back(parse_byte(in_byte));
			if (out_valid && out_ready) begin
				checked++;
				if (expected_status_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected status %0d with nothing pending",
							$realtime, out_status);
				end else begin
					exp_r = expected_status_q.pop_front();
					if (exp_r.status == ST_COMPLETE)
						completes++;
					if (exp_r.status == ST_REJECTED)
						rejects++;
					if (exp_r.status !== out_status || exp_r.channel !== out_channel ||
						exp_r.min_pwm !== out_min_pwm || exp_r.max_pwm !== out_max_pwm) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: st/ch/min/max exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								$realtime, exp_r.status, exp_r.channel, exp_r.min_pwm,
								exp_r.max_pwm, out_status, out_channel, out_min_pwm,
								out_max_pwm);
					end
				end
			end
		end
		pending = expected_status_q.size();
	end

endmodule

FILE: tb/sv/tb.sv
// top of the pwm command frame parser testbench: clock, reset, byte stimulus, verdict
`timescale 1ns / 100ps

module tb;
	import pcfp_pkg::*;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   checked;
	int   completes;
	int   rejects;
	int   tx_idle_pct;
	int   rx_stall_pct;
	int   hold_left;
	int   bytes_sent;

	pcfp_rx_if  rx_ch();
	pcfp_res_if res_ch();

	pwm_command_frame_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	pcfp_frame_check frame_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (rx_ch.valid),
		.in_ready    (rx_ch.ready),
		.in_byte     (rx_ch.rx_byte),
		.out_valid   (res_ch.valid),
		.out_ready   (res_ch.ready),
		.out_status  (res_ch.frame_status),
		.out_channel (res_ch.channel_out),
		.out_min_pwm (res_ch.min_pwm_out),
		.out_max_pwm (res_ch.max_pwm_out),
		.mismatches  (mismatches),
		.pending     (pending),
		.checked     (checked),
		.completes   (completes),
		.rejects     (rejects)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver side: random stalls plus a single long hold-off at the start of the first random phase
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		bytes_sent++;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		rx_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// mostly good frames with random fields, some corrupted, cut short or padded with noise
	task automatic send_frame();
		logic [7:0] fr[6];
		int         bad;
		int         n;
		fr[0] = BYTE_START;
		fr[1] = BYTE_LENGTH;
		fr[2] = 8'($urandom_range(16));
		fr[3] = 8'($urandom_range(25, 10));
		fr[4] = 8'($urandom_range(25, 10));
		fr[5] = BYTE_END;
		if ($urandom_range(99) < 25) begin
			bad = $urandom_range(5);
			unique case (bad)
				2: fr[2] = 8'($urandom_range(255, 17));
				3, 4: fr[bad] = $urandom_range(1) ? 8'($urandom_range(9))
					: 8'($urandom_range(255, 26));
				default: fr[bad] = 8'($urandom_range(255));
			endcase
		end
		n = 6;
		if ($urandom_range(99) < 10)
			n = $urandom_range(5, 1);
		for (int i = 0; i < n; i++)
			send_byte(fr[i]);
		if ($urandom_range(99) < 20)
			repeat ($urandom_range(3, 1))
				send_byte(8'($urandom_range(255)));
	endtask

	initial begin
		logic [7:0] directed[$];
		int         target;
		directed = '{8'h00, 8'hFF,
			BYTE_START, BYTE_LENGTH, 8'd16, 8'd10, 8'd25, BYTE_END,
			8'h55,
			BYTE_START, BYTE_LENGTH, 8'd0, 8'd25, 8'd10, BYTE_END,
			BYTE_START, BYTE_LENGTH, 8'd17,
			BYTE_START, BYTE_LENGTH, 8'd4, BYTE_START, 8'h07,
			BYTE_START, BYTE_LENGTH, 8'd3, 8'd26};
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_left = 0;
		bytes_sent = 0;
		arst_n = 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_byte(directed[i]);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			unique case (ph)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 82; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 82; end
				default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
			endcase
			if (ph == 0)
				hold_left = 60;
			target = bytes_sent + 310;
			while (bytes_sent < target)
				send_frame();
			wait_drained();
		end

		repeat (10) @(posedge clk);
		$display("run: %0d bytes sent, %0d statuses checked", bytes_sent, checked);
		$display("run: %0d frames completed, %0d rejects seen", completes, rejects);
		if (mismatches == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
